// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
// No dependencies. Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/osa_pkg.sv -----
// Package for the owner-tagged slot allocator: defaults, codes, register map.
// No dependencies.
`default_nettype none

package osa_pkg;

    localparam int TABLE_DEPTH_DEF = 128;
    localparam int OWNER_COUNT_DEF = 32;

    // request codes
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // APB register map: word index is paddr[2]
    localparam int         PADDR_W       = 3;
    localparam logic       CFG_IDX_SLOTS = 1'b0;
    localparam logic [7:0] SLOTS_RESET   = 8'd128;

endpackage

`default_nettype wire

// ----- rtl/core/osa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module osa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/owner_tagged_slot_allocator.sv -----
// Owner-tagged slot allocator top level: APB config, request sequencer, slot table.
// Depends on osa_pkg, osa_ram and assert_macros.svh.
//
//  channel   | handshake                              | payload
//  ----------+----------------------------------------+-------------------------------------
//  request   | start, busy (taken on start & !busy)   | i_req_type, i_owner, i_slot_count
//  result    | o_done strobe, one cycle, no backpress | o_granted, o_free_slots, o_owner_slots
//  config    | APB psel/penable/pwrite, pready = 1    | paddr, pwdata, prdata
//
// Sequence: while busy, a counting pass reads the first n entries, n = min(slots_in_use,
// TABLE_DEPTH); a decide step follows, then, only when the table is modified, a fill/clear
// pass over the same entries; the result strobe comes as busy falls. Both passes go through
// the single read port of the slot RAM, one entry per cycle.
// Reset: synchronous, active low; then a clearing pass over all TABLE_DEPTH entries, busy high.
// Stalls: none on the result side; the result strobe pulses once per transaction.
`default_nettype none

module owner_tagged_slot_allocator
    import osa_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int OWNER_COUNT = OWNER_COUNT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_req_type,
    input  wire logic [4:0]         i_owner,
    input  wire logic [7:0]         i_slot_count,
    // result
    output logic                    o_done,
    output logic                    o_granted,
    output logic [7:0]              o_free_slots,
    output logic [7:0]              o_owner_slots,
    // APB config
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    // address, count, wide-compare, owner and entry widths
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int NW  = (CW > 8) ? CW : 8;
    localparam int OW  = $clog2(OWNER_COUNT);
    localparam int OCW = (OW > 5) ? OW : 5;
    localparam int EW  = OW + 1;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_COUNT  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_MODIFY = 3'd4;

    // control
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_addr, n_addr;      // read issue pointer, also clear sweep
    logic          r_rd_vld, n_rd_vld;  // RAM data valid this cycle
    logic          r_done, n_done;
    logic [7:0]    r_slots_in_use;

    // transaction data
    logic          r_req, n_req;
    logic [4:0]    r_who, n_who;
    logic [7:0]    r_cnt, n_cnt;
    logic [CW-1:0] r_n, n_n;            // active slot count
    logic [AW-1:0] r_rd_addr, n_rd_addr;
    logic [CW-1:0] r_free, n_free;
    logic [CW-1:0] r_own, n_own;
    logic [7:0]    r_left, n_left;
    logic          r_granted, n_granted;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic          ram_re;
    logic [EW-1:0] ram_rdata;

    // combinational helpers
    logic          who_ok;
    logic          rd_used;
    logic          rd_match_own;
    logic          rd_match;
    logic          issue;
    logic          grant;
    logic [NW-1:0] slots_wide;
    logic [NW-1:0] free_wide;
    logic [NW-1:0] own_wide;
    logic [NW-1:0] cnt_wide;
    logic          cfg_wr;

    // ---------------------------------------------------------------------
    // APB configuration: one register, slots_in_use, at word 0
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= SLOTS_RESET;
        end else if (cfg_wr && (paddr[2] == CFG_IDX_SLOTS)) begin
            r_slots_in_use <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == CFG_IDX_SLOTS) ? 32'(r_slots_in_use) : '0;

    // ---------------------------------------------------------------------
    // Slot table: entry = {used, owner}
    // ---------------------------------------------------------------------
    osa_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // owners at or above OWNER_COUNT are refused outright
    assign who_ok = (OCW + 1)'(r_who) < (OCW + 1)'(OWNER_COUNT);

    assign rd_used      = ram_rdata[EW-1];
    assign rd_match_own = rd_used && (OCW'(ram_rdata[OW-1:0]) == OCW'(r_who));
    assign rd_match     = (r_req == REQ_ALLOC) ? !rd_used : rd_match_own;

    // one read per cycle while the pointer is inside the active range
    assign issue  = (r_addr != r_n);
    assign ram_re = ((r_state == S_COUNT) || (r_state == S_MODIFY)) && issue;

    assign slots_wide = NW'(r_slots_in_use);
    assign free_wide  = NW'(r_free);
    assign own_wide   = NW'(r_own);
    assign cnt_wide   = NW'(r_cnt);

    assign grant = who_ok && ((r_req == REQ_ALLOC) ? (free_wide >= cnt_wide)
                                                   : (own_wide >= cnt_wide));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_rd_addr;
        ram_wdata = '0;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_addr[AW-1:0];
        end else if ((r_state == S_MODIFY) && r_rd_vld && (r_left != 8'd0) && rd_match) begin
            ram_we = 1'b1;
            // allocate tags the slot, release frees it
            if (r_req == REQ_ALLOC) begin
                ram_wdata = {1'b1, OW'(r_who)};
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_rd_vld  = 1'b0;
        n_done    = 1'b0;
        n_req     = r_req;
        n_who     = r_who;
        n_cnt     = r_cnt;
        n_n       = r_n;
        n_rd_addr = r_addr[AW-1:0];
        n_free    = r_free;
        n_own     = r_own;
        n_left    = r_left;
        n_granted = r_granted;

        unique case (r_state)
            S_CLEAR: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == CW'(TABLE_DEPTH - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req  = i_req_type;
                    n_who  = i_owner;
                    n_cnt  = i_slot_count;
                    // slots_in_use beyond the table counts as the whole table
                    n_n    = (slots_wide > NW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                             : CW'(slots_wide);
                    n_addr = '0;
                    n_free = '0;
                    n_own  = '0;
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                if (issue) begin
                    n_addr = r_addr + 1'b1;
                end
                n_rd_vld = issue;
                if (r_rd_vld) begin
                    if (!rd_used) begin
                        n_free = r_free + 1'b1;
                    end
                    if (rd_match_own) begin
                        n_own = r_own + 1'b1;
                    end
                end
                if (!issue && !r_rd_vld) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_granted = grant;
                if (grant) begin
                    if (r_req == REQ_ALLOC) begin
                        n_free = CW'(free_wide - cnt_wide);
                        n_own  = CW'(own_wide + cnt_wide);
                    end else begin
                        n_free = CW'(free_wide + cnt_wide);
                        n_own  = CW'(own_wide - cnt_wide);
                    end
                end
                if (!who_ok) begin
                    n_own = '0;
                end
                n_addr = '0;
                n_left = r_cnt;
                if (grant && (r_cnt != 8'd0)) begin
                    n_state = S_MODIFY;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MODIFY: begin
                if (issue) begin
                    n_addr = r_addr + 1'b1;
                end
                n_rd_vld = issue;
                if (ram_we) begin
                    n_left = r_left - 1'b1;
                end
                if (!issue && !r_rd_vld) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_rd_vld <= n_rd_vld;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_who     <= n_who;
        r_cnt     <= n_cnt;
        r_n       <= n_n;
        r_rd_addr <= n_rd_addr;
        r_free    <= n_free;
        r_own     <= n_own;
        r_left    <= n_left;
        r_granted <= n_granted;
    end

    // outputs: counts are reported modulo 256
    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_granted     = r_granted;
    assign o_free_slots  = free_wide[7:0];
    assign o_owner_slots = own_wide[7:0];

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `include "assert_macros.svh"

    `ASSERT_NEXT(a_done_single, o_done, !o_done, "result strobe longer than one cycle")
    `ASSERT_NEXT(a_accept_count, start && !busy, r_state == S_COUNT, "no count after accept")
    `ASSERT_ALWAYS(a_we_phase, !ram_we || r_state == S_CLEAR || r_state == S_MODIFY, "stray write")
    `ASSERT_ALWAYS(a_grant_owner, !(o_done && o_granted) || who_ok, "bad owner granted")
    `ASSERT_ALWAYS(a_free_range, !o_done || (r_free <= r_n), "free count above n")

endmodule

`default_nettype wire
